// File: rtl/nttg_pkg.sv
// Shared types, codes and constants for the nearest-target go-to-goal block.
// Used by every module in rtl/; depends on nothing.
package nttg_pkg;

  // default parameter values
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_FRAC_DEF   = 11;

  // fixed datapath widths
  localparam int COORD_W  = 16;   // Q5.11 coordinates, Q3.13 heading
  localparam int DIFF_W   = 17;   // coordinate differences
  localparam int CV_W     = 32;   // CORDIC x/y
  localparam int Z_W      = 34;   // CORDIC angle, Q.30
  localparam int DSQ_W    = 34;   // squared distance
  localparam int DIST_W   = 17;   // distance after 1/K scaling
  localparam int ERR_W    = 18;   // heading error, Q5.13
  localparam int SPEED_W  = 18;
  localparam int ID_W     = 8;
  localparam int RAD_W    = 13;
  localparam int GAIN_W   = 12;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 64;
  localparam int IDX_W    = 5;    // atan table index
  localparam int ATAN_N   = 24;
  localparam int PRESCALE = 12;

  localparam logic signed [Z_W-1:0]   PI_Q30     = 34'sd3373259426;
  localparam logic signed [Z_W-1:0]   TWO_PI_Q30 = 34'sd6746518852;
  localparam logic signed [ERR_W-1:0] PI_Q13     = 18'sd25736;
  localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 18'sd51472;
  localparam logic signed [MUL_W-1:0] INV_K_Q30  = 32'sd652032874;
  localparam int FWD_MAX  = 262143;
  localparam int TURN_MAX = 131071;
  localparam int TURN_MIN = -131072;

  // register reset values
  localparam logic              CLOSEST_RST = 1'b1;
  localparam logic [RAD_W-1:0]  RADIUS_RST  = 13'd1024;
  localparam logic [GAIN_W-1:0] LIN_GAIN_RST = 12'd512;
  localparam logic [GAIN_W-1:0] ANG_GAIN_RST = 12'd1536;

  typedef enum logic [1:0] {
    KIND_POSE  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_CLOSEST_MODE = 2'd0,
    CFG_CATCH_RADIUS = 2'd1,
    CFG_LINEAR_GAIN  = 2'd2,
    CFG_ANGULAR_GAIN = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DSQ_X,
    ST_DSQ_Y,
    ST_DSQ_SUM,
    ST_CORDIC_LOAD,
    ST_CORDIC_RUN,
    ST_SCALE,
    ST_DIST,
    ST_FWD,
    ST_TURN,
    ST_TURN_DONE,
    ST_OUT
  } state_t;

  // atan(2^-i) in Q.30
  function automatic logic [29:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/nttg_mul.sv
// Shared signed multiplier with registered product.
// Depends on nttg_pkg.
module nttg_mul import nttg_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: rtl/nttg_cordic.sv
// Vectoring CORDIC, one micro-rotation per cycle, with right-half-plane pre-rotation.
// Depends on nttg_pkg.
module nttg_cordic import nttg_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  output logic signed [CV_W-1:0]  x,
  output logic signed [Z_W-1:0]   z,
  output logic                    busy
);

  logic signed [CV_W-1:0] y;
  logic [IDX_W-1:0]       cnt;
  logic signed [CV_W-1:0] x0, y0, xsh, ysh;
  logic signed [Z_W-1:0]  a_step;

  assign x0     = CV_W'(dx) <<< PRESCALE;
  assign y0     = CV_W'(dy) <<< PRESCALE;
  assign xsh    = x >>> cnt;
  assign ysh    = y >>> cnt;
  assign a_step = Z_W'($signed({1'b0, atan_q30(cnt)}));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == IDX_W'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // left half plane: rotate by pi first
      if (x0 < 0) begin
        x <= -x0;
        y <= -y0;
        z <= PI_Q30;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + ysh;
        y <= y - xsh;
        z <= z + a_step;
      end else begin
        x <= x - ysh;
        y <= y + xsh;
        z <= z - a_step;
      end
    end
  end

endmodule

// File: rtl/nearest_target_go_to_goal.sv
// Top level of the nearest-target go-to-goal controller: stream ports, state,
// sequencer. Depends on nttg_pkg, nttg_mul, nttg_cordic.

// One item enters at a time; s_tready is high only while the sequencer idles.
// Pose updates, empty-list items and ticks that find no pose or no target
// are handled in the idle state. A list entry makes two passes through the
// shared multiplier for dx*dx and dy*dy, then the compare against the kept entry.
// A tick that produces a result passes from accept to the result register
// through a load state, one CORDIC micro-rotation per cycle, then the shared
// multiplier used in turn for the 1/K scaling, linear_gain * distance and
// angular_gain * error. A catch result skips the angular_gain product and
// discards the linear one. The result sits in an output register; a tick that
// finds that register still full waits for it to drain.
// Configuration writes land on any cycle and must be made while the block idles.
module nearest_target_go_to_goal import nttg_pkg::*; #(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // pos_x[15:0], pos_y[31:16], heading[47:32], entry_id[55:48]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  input  logic        s_tlast,   // last_entry
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // forward_speed[17:0], turn_rate[35:18], caught_id[43:36], zero
  output logic [0:0]  m_tuser,   // catch_request[0]
  // register writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_data
);

  localparam int TURN_SH = 21 - COORD_FRAC_BITS;

  state_t state, state_next;

  // registers
  logic              closest_mode;
  logic [RAD_W-1:0]  catch_radius;
  logic [GAIN_W-1:0] linear_gain, angular_gain;

  // pose, goal and list search state
  logic signed [COORD_W-1:0] self_x, self_y, self_heading;
  logic                      pose_valid, target_valid, list_open;
  logic signed [COORD_W-1:0] goal_x, goal_y, best_x, best_y;
  logic [ID_W-1:0]           goal_id, best_id;
  logic [DSQ_W-1:0]          best_dist_sq;

  // latched list entry
  logic signed [COORD_W-1:0] ent_x, ent_y;
  logic [ID_W-1:0]           ent_id;
  logic                      ent_last;
  logic [DSQ_W-1:0]          dsq_acc;

  // tick datapath
  logic [DIST_W-1:0]        goal_dist;
  logic signed [ERR_W-1:0]  err;
  logic [SPEED_W-1:0]       res_fwd;
  logic signed [SPEED_W-1:0] res_turn;
  logic                     res_catch;
  logic [ID_W-1:0]          res_id;

  // shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     cor_start, cor_busy;
  logic signed [CV_W-1:0]   cor_x;
  logic signed [Z_W-1:0]    cor_z;
  logic signed [DIFF_W-1:0] cor_dx, cor_dy;

  logic accept;
  kind_t in_kind;
  logic signed [COORD_W-1:0] in_x, in_y, in_heading;

  assign accept     = s_tvalid && s_tready;
  assign in_kind    = kind_t'(s_tuser);
  assign in_x       = $signed(s_tdata[15:0]);
  assign in_y       = $signed(s_tdata[31:16]);
  assign in_heading = $signed(s_tdata[47:32]);

  nttg_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign cor_dx = DIFF_W'(goal_x) - DIFF_W'(self_x);
  assign cor_dy = DIFF_W'(goal_y) - DIFF_W'(self_y);

  nttg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .dx    (cor_dx),
    .dy    (cor_dy),
    .x     (cor_x),
    .z     (cor_z),
    .busy  (cor_busy)
  );

  // ---- combinational datapath ----
  logic signed [DIFF_W-1:0] ent_dx, ent_dy;
  logic [DSQ_W-1:0]         dsq;
  logic                     take_entry;
  logic signed [CV_W-1:0]   x_cl;
  logic signed [Z_W-1:0]    z_wrap, z_rnd;
  logic signed [DIFF_W-1:0] bearing;
  logic signed [ERR_W-1:0]  err_raw, err_wrap;
  logic signed [PROD_W-1:0] dist_sum, fwd_sum, turn_sum, turn_sh;
  logic [PROD_W-9:0]        fwd_sh;

  assign ent_dx = DIFF_W'(ent_x) - DIFF_W'(self_x);
  assign ent_dy = DIFF_W'(ent_y) - DIFF_W'(self_y);
  assign dsq    = dsq_acc + mul_p[DSQ_W-1:0];
  // first entry of a run always kept; later ones only in closest mode and if strictly nearer
  assign take_entry = !list_open || (closest_mode && (dsq < best_dist_sq));

  assign x_cl = cor_x[CV_W-1] ? '0 : cor_x;

  // bearing wrapped into (-pi, pi], rounded half up to Q3.13
  assign z_wrap  = (cor_z > PI_Q30) ? (cor_z - TWO_PI_Q30) : cor_z;
  assign z_rnd   = z_wrap + 34'sd65536;
  assign bearing = z_rnd[Z_W-1:17];
  assign err_raw = ERR_W'(bearing) - ERR_W'(self_heading);
  always_comb begin
    if (err_raw > PI_Q13) begin
      err_wrap = err_raw - TWO_PI_Q13;
    end else if (err_raw < -PI_Q13) begin
      err_wrap = err_raw + TWO_PI_Q13;
    end else begin
      err_wrap = err_raw;
    end
  end

  assign dist_sum = mul_p + (64'sd1 <<< (29 + PRESCALE));
  assign fwd_sum  = mul_p + 64'sd128;
  assign fwd_sh   = fwd_sum[PROD_W-1:8];
  assign turn_sum = mul_p + (64'sd1 <<< (TURN_SH - 1));
  assign turn_sh  = turn_sum >>> TURN_SH;

  // ---- sequencer: next state ----
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (in_kind)
            KIND_ENTRY: state_next = ST_DSQ_X;
            KIND_TICK:  state_next = (pose_valid && target_valid) ? ST_CORDIC_LOAD : ST_IDLE;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_DSQ_X:       state_next = ST_DSQ_Y;
      ST_DSQ_Y:       state_next = ST_DSQ_SUM;
      ST_DSQ_SUM:     state_next = ST_IDLE;
      ST_CORDIC_LOAD: state_next = ST_CORDIC_RUN;
      ST_CORDIC_RUN:  state_next = cor_busy ? ST_CORDIC_RUN : ST_SCALE;
      ST_SCALE:       state_next = ST_DIST;
      ST_DIST:        state_next = ST_FWD;
      ST_FWD:         state_next = (goal_dist > DIST_W'(catch_radius)) ? ST_TURN : ST_OUT;
      ST_TURN:        state_next = ST_TURN_DONE;
      ST_TURN_DONE:   state_next = ST_OUT;
      ST_OUT:         state_next = (!m_tvalid || m_tready) ? ST_IDLE : ST_OUT;
      default:        state_next = ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs ----
  always_comb begin
    s_tready  = 1'b0;
    cor_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      ST_IDLE:        s_tready  = 1'b1;
      ST_CORDIC_LOAD: cor_start = 1'b1;
      ST_DSQ_X: begin
        mul_a = MUL_W'(ent_dx);
        mul_b = MUL_W'(ent_dx);
      end
      ST_DSQ_Y: begin
        mul_a = MUL_W'(ent_dy);
        mul_b = MUL_W'(ent_dy);
      end
      ST_SCALE: begin
        mul_a = x_cl;
        mul_b = INV_K_Q30;
      end
      ST_FWD: begin
        mul_a = MUL_W'($signed({1'b0, linear_gain}));
        mul_b = MUL_W'($signed({1'b0, goal_dist}));
      end
      ST_TURN: begin
        mul_a = MUL_W'($signed({1'b0, angular_gain}));
        mul_b = MUL_W'(err);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- register file ----
  always_ff @(posedge clk) begin
    if (rst) begin
      closest_mode <= CLOSEST_RST;
      catch_radius <= RADIUS_RST;
      linear_gain  <= LIN_GAIN_RST;
      angular_gain <= ANG_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_CLOSEST_MODE: closest_mode <= cfg_data[0];
        CFG_CATCH_RADIUS: catch_radius <= cfg_data;
        CFG_LINEAR_GAIN:  linear_gain  <= cfg_data[GAIN_W-1:0];
        CFG_ANGULAR_GAIN: angular_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- pose, list and goal state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      self_x       <= '0;
      self_y       <= '0;
      self_heading <= '0;
      pose_valid   <= 1'b0;
      target_valid <= 1'b0;
      list_open    <= 1'b0;
      goal_x       <= '0;
      goal_y       <= '0;
      goal_id      <= '0;
      best_x       <= '0;
      best_y       <= '0;
      best_id      <= '0;
      best_dist_sq <= '0;
    end else begin
      if (accept) begin
        case (in_kind)
          KIND_POSE: begin
            self_x       <= in_x;
            self_y       <= in_y;
            self_heading <= in_heading;
            pose_valid   <= 1'b1;
          end
          KIND_EMPTY: begin
            // also abandons an open run
            target_valid <= 1'b0;
            list_open    <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state == ST_DSQ_SUM) begin
        if (take_entry) begin
          best_x       <= ent_x;
          best_y       <= ent_y;
          best_id      <= ent_id;
          best_dist_sq <= dsq;
        end
        if (ent_last) begin
          goal_x       <= take_entry ? ent_x : best_x;
          goal_y       <= take_entry ? ent_y : best_y;
          goal_id      <= take_entry ? ent_id : best_id;
          target_valid <= 1'b1;
          list_open    <= 1'b0;
        end else begin
          list_open <= 1'b1;
        end
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (accept && in_kind == KIND_ENTRY) begin
      ent_x    <= in_x;
      ent_y    <= in_y;
      ent_id   <= s_tdata[55:48];
      ent_last <= s_tlast;
    end
    if (state == ST_DSQ_Y) begin
      dsq_acc <= mul_p[DSQ_W-1:0];
    end
    if (state == ST_DIST) begin
      goal_dist <= dist_sum[DIST_W+29+PRESCALE:30+PRESCALE];
      err       <= err_wrap;
    end
    if (state == ST_FWD) begin
      res_fwd   <= '0;
      res_turn  <= '0;
      res_catch <= !(goal_dist > DIST_W'(catch_radius));
      res_id    <= (goal_dist > DIST_W'(catch_radius)) ? '0 : goal_id;
    end
    if (state == ST_TURN) begin
      res_fwd <= (fwd_sh > (PROD_W-8)'(FWD_MAX)) ? SPEED_W'(FWD_MAX) : fwd_sh[SPEED_W-1:0];
    end
    if (state == ST_TURN_DONE) begin
      if (turn_sh > 64'sd131071) begin
        res_turn <= SPEED_W'(TURN_MAX);
      end else if (turn_sh < -64'sd131072) begin
        res_turn <= SPEED_W'(TURN_MIN);
      end else begin
        res_turn <= turn_sh[SPEED_W-1:0];
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'b0, res_id, res_turn, res_fwd};
      m_tuser <= res_catch;
    end
  end

  // ---- assertions ----
  a_idle_cordic: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cor_busy)
    else $error("item accepted while CORDIC busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && m_tvalid && !m_tready) |=> (state == ST_OUT && m_tvalid))
    else $error("pending result lost");

  a_catch_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[35:0] == 36'd0))
    else $error("catch result with nonzero speed");

  a_drive_id: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[43:36] == 8'd0))
    else $error("drive result with nonzero caught_id");

endmodule
